### hw/rtl/tcw_pkg.sv
// shared constants, types and command/status structs for the text console writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 11;
    localparam int NUM_W   = 32;
    localparam int NDIG    = 10;
    localparam int CNT_W   = 4;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;
    localparam logic [7:0] MINUS_SIGN   = 8'h2D;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [NUM_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_DIVQ,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_q;
        logic conv_step;
        logic newline;
        logic emit_char;
        logic emit_sign;
        logic emit_digit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic char_nl;
        logic num_neg;
        logic q_zero;
        logic last_digit;
    } t_dp_sts;

endpackage

### hw/rtl/tcw_ctrl.sv
// controller state machine for the text console writer
// depends on tcw_pkg; drives tcw_dp through t_dp_cmd
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_mode ? ST_DIVQ : ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (i_sts.char_nl) begin
                    o_cmd.newline = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_DIVQ: begin
                o_cmd.calc_q = 1'b1;
                n_state      = ST_CONV;
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                // quotient already zero: this is the most significant digit
                if (i_sts.q_zero) begin
                    n_state = i_sts.num_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    o_cmd.last       = i_sts.last_digit;
                    if (i_sts.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/tcw_dp.sv
// datapath: cursor, attribute register, divide-by-ten digit loop, output register
// depends on tcw_pkg; commanded by tcw_ctrl
`timescale 1ns / 1ps

module tcw_dp
    import tcw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [7:0]              i_cfg_data,
    input  logic [7:0]              i_char_code,
    input  logic signed [NUM_W-1:0] i_number,
    input  logic                    i_out_stall,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    output logic [ADDR_W-1:0]       o_cell_address,
    output logic [15:0]             o_cell_word,
    output logic                    o_is_last
);

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [7:0]        r_attr;
    logic [7:0]        r_char;
    logic              r_neg;
    logic [NUM_W-1:0]  r_mag;
    logic [NUM_W-1:0]  r_q;
    logic [3:0]        r_dig [NDIG];
    logic [CNT_W-1:0]  r_nd;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [15:0]       r_word;
    logic              r_last;

    logic [COL_W-1:0]   eff_col;
    logic [ROW_W-1:0]   eff_row;
    logic [ROW_W-1:0]   inc_row;
    logic [ADDR_W:0]    addr_full;
    logic [NUM_W-1:0]   mul_in;
    logic [2*NUM_W-1:0] prod;
    logic [NUM_W-1:0]   q_next;
    logic [3:0]         digit;
    logic [7:0]         emit_code;
    logic               emit;
    logic               out_free;
    logic [NUM_W-1:0]   num_u;

    // next row with wrap to row 0
    always_comb begin
        inc_row = r_row + ROW_W'(1);
        if (inc_row >= ROW_W'(ROWS)) begin
            inc_row = '0;
        end
    end

    // lazy wrap of a full row just before a cell write
    always_comb begin
        if (r_col >= COL_W'(COLUMNS)) begin
            eff_col = '0;
            eff_row = inc_row;
        end else begin
            eff_col = r_col;
            eff_row = r_row;
        end
        if (eff_row >= ROW_W'(ROWS)) begin
            eff_row = '0;
        end
        addr_full = (ADDR_W+1)'(eff_row) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(eff_col);
    end

    // one quotient per cycle by reciprocal multiply
    assign mul_in = i_cmd.calc_q ? r_mag : r_q;
    assign prod   = {{NUM_W{1'b0}}, mul_in} * {{NUM_W{1'b0}}, RECIP10};
    assign q_next = NUM_W'(prod[2*NUM_W-1:RECIP_SHIFT]);
    // remainder is below ten, so only the low nibble of mag - 10q matters
    assign digit  = r_mag[3:0] - ({r_q[0], 3'b000} + {r_q[2:0], 1'b0});

    assign num_u = i_number[NUM_W-1] ? (~NUM_W'(i_number) + NUM_W'(1)) : NUM_W'(i_number);

    assign emit     = i_cmd.emit_char | i_cmd.emit_sign | i_cmd.emit_digit;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (i_cmd.emit_sign) begin
            emit_code = MINUS_SIGN;
        end else if (i_cmd.emit_digit) begin
            emit_code = DIGIT_ZERO | {4'h0, r_dig[0]};
        end else begin
            emit_code = r_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.newline) begin
                r_col <= '0;
                r_row <= inc_row;
            end else if (emit) begin
                r_col <= eff_col + COL_W'(1);
                r_row <= eff_row;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_neg  <= i_number[NUM_W-1];
            r_mag  <= num_u;
            r_nd   <= '0;
        end
        if (i_cmd.calc_q) begin
            r_q <= q_next;
        end
        if (i_cmd.conv_step) begin
            r_mag    <= r_q;
            r_q      <= q_next;
            r_nd     <= r_nd + CNT_W'(1);
            r_dig[0] <= digit;
            for (int i = 1; i < NDIG; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
        end
        if (i_cmd.emit_digit) begin
            r_nd <= r_nd - CNT_W'(1);
            for (int i = 0; i < NDIG - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
        if (emit) begin
            r_addr <= addr_full[ADDR_W-1:0];
            r_word <= {r_attr, emit_code};
            r_last <= i_cmd.last;
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.char_nl    = (r_char == NEWLINE_CODE);
    assign o_sts.num_neg    = r_neg;
    assign o_sts.q_zero     = (r_q == '0);
    assign o_sts.last_digit = (r_nd == CNT_W'(1));

    assign o_out_valid    = r_out_valid;
    assign o_cell_address = r_addr;
    assign o_cell_word    = r_word;
    assign o_is_last      = r_last;

endmodule

### hw/rtl/text_console_writer.sv
// top level of the text console writer: controller plus datapath
// depends on tcw_pkg, tcw_ctrl, tcw_dp
`timescale 1ns / 1ps

// Prints characters and signed 32-bit integers onto an 80x25 text screen as a
// stream of cell writes (address, attribute<<8 | code, last flag). A character
// transaction is accepted, then its cell write goes into the output register;
// a newline writes nothing. For an integer, ST_DIVQ forms the first quotient,
// a divide-by-ten loop in ST_CONV produces one digit per cycle with a
// reciprocal multiply, then an optional minus sign and the digits leave one
// per cycle, while the output is not stalled, through the single output
// register. A stall on the output side holds the block until the output
// register is free. The block takes a new item while the last result of the
// previous one still waits in the output register. The attribute register
// may be written only while the block is idle.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [7:0]              i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_mode,
    input  logic [7:0]              i_char_code,
    input  logic signed [NUM_W-1:0] i_number,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ADDR_W-1:0]       o_cell_address,
    output logic [15:0]             o_cell_word,
    output logic                    o_is_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tcw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_char_code    (i_char_code),
        .i_number       (i_number),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_cell_address (o_cell_address),
        .o_cell_word    (o_cell_word),
        .o_is_last      (o_is_last)
    );

endmodule

### hw/rtl/tcw_chk.sv
// port-level checker for the text console writer, bound to the top level
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_chk
    import tcw_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic [7:0]              i_cfg_data,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_mode,
    input logic [7:0]              i_char_code,
    input logic signed [NUM_W-1:0] i_number,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [ADDR_W-1:0]       o_cell_address,
    input logic [15:0]             o_cell_word,
    input logic                    o_is_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cell_address < ADDR_W'(CELLS)))
        else $error("cell address off screen");

    // a number still being printed keeps the input closed
    a_busy_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_in_stall)
        else $error("input open in the middle of a number");

    a_mid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |->
            (o_cell_word[7:0] == MINUS_SIGN) ||
            ((o_cell_word[7:0] >= DIGIT_ZERO) && (o_cell_word[7:0] <= DIGIT_NINE)))
        else $error("unexpected code inside a number");

endmodule

bind text_console_writer tcw_chk u_chk (.*);
